[rtl/rrru_pkg.sv]
// ----------------------------------------------------------------------------
// rrru_pkg: shared widths, types and helpers for the reflect/refract unit
// Fixed-point widths of every pipeline field, the payload carried by the
// divider and square-root cell chains, and the rounding/saturation helpers.
// ----------------------------------------------------------------------------
package rrru_pkg;

  // Fraction bits of every fixed-point value
  localparam int FRAC_BITS = 16;

  localparam int VEC_W   = 18;                  // Q2.F vector component
  localparam int IDX_W   = 16;                  // Q4.12 refractive index
  localparam int OUT_W   = 21;                  // Q5.F result component
  localparam int ETA_W   = FRAC_BITS + 4;       // eta, saturated below 16.0
  localparam int EXT_W   = ETA_W - FRAC_BITS;   // integer bits of eta
  localparam int PRD_W   = 2 * VEC_W;           // one component product
  localparam int DOT_W   = 2 * VEC_W + 2;       // exact dot product
  localparam int KF_W    = DOT_W - FRAC_BITS;   // rounded dot product
  localparam int NVF_W   = VEC_W + 1;           // normal after flip
  localparam int COS_W   = FRAC_BITS + 2;       // clamped cosine
  localparam int KN_W    = KF_W + NVF_W;
  localparam int E2_W    = 2 * ETA_W - FRAC_BITS + 1;
  localparam int Q_W     = 2 * COS_W + 2 - FRAC_BITS;
  localparam int EC_W    = ETA_W + COS_W + 1 - FRAC_BITS;
  localparam int EQ_W    = E2_W + 1 + Q_W;
  localparam int SQ_W    = FRAC_BITS + 7;       // square-root result bits
  localparam int RAD_W   = 2 * SQ_W;            // radicand bits
  localparam int M_W     = ((EC_W > SQ_W) ? EC_W : SQ_W) + 2;
  localparam int EI_W    = ETA_W + 1 + VEC_W;
  localparam int MN_W    = M_W + NVF_W;

  localparam int IN_DATA_W  = ((6 * VEC_W + 2 * IDX_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - 3 * OUT_W;

  localparam logic [ETA_W-1:0] ETA_MAX = {ETA_W{1'b1}};
  localparam logic [COS_W-1:0] COS_MAX = {COS_W{1'b1}};

  localparam logic signed [63:0] ONE    = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] ONE_SQ = 64'sd1 <<< (2 * FRAC_BITS);
  localparam logic signed [63:0] HALF   = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] OUT_HI = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_LO = -(64'sd1 <<< (OUT_W - 1));

  // Divider chain beat: one quotient bit per cell
  typedef struct packed {
    logic                       mode;
    logic [2:0][VEC_W-1:0]      iv;
    logic [2:0][VEC_W-1:0]      nv;
    logic [IDX_W-1:0]           to_v;
    logic [ETA_W-1:0]           dbits;
    logic [IDX_W-1:0]           rem;
    logic [ETA_W-1:0]           quo;
    logic                       sat;
  } div_t;

  // Square-root chain beat: one root bit per cell
  typedef struct packed {
    logic                       mode;
    logic                       tir;
    logic [2:0][VEC_W-1:0]      iv;
    logic [2:0][NVF_W-1:0]      nvf;
    logic [ETA_W-1:0]           eta;
    logic [EC_W-1:0]            ecr;
    logic [2:0][OUT_W-1:0]      refl;
    logic [RAD_W-1:0]           rad;
    logic [SQ_W+1:0]            rem;
    logic [SQ_W-1:0]            root;
  } sq_t;

  // Round to nearest, ties up, dropping the fraction bits
  function automatic logic signed [63:0] rescale(input logic signed [63:0] v);
    return (v + HALF) >>> FRAC_BITS;
  endfunction

  // Clamp to the output component range
  function automatic logic [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (c > OUT_HI) c = OUT_HI;
    if (c < OUT_LO) c = OUT_LO;
    return c[OUT_W-1:0];
  endfunction

endpackage

[rtl/rrru_div_cell.sv]
// ----------------------------------------------------------------------------
// rrru_div_cell: one restoring-division step of the eta divider chain
// Shifts in one dividend bit, trial-subtracts the divisor and emits one
// quotient bit, then hands the beat to the next cell.
// ----------------------------------------------------------------------------
module rrru_div_cell
  import rrru_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  div_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output div_t dn_data
);

  logic             valid_r;
  div_t             data_r;
  div_t             data_nxt;
  logic [IDX_W:0]   trial;
  logic [IDX_W:0]   diff;
  logic             ge;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Trial subtract and shift one quotient bit in
  always_comb begin
    trial    = {up_data.rem, up_data.dbits[ETA_W-1]};
    diff     = trial - {1'b0, up_data.to_v};
    ge       = (trial >= {1'b0, up_data.to_v});
    data_nxt = up_data;
    data_nxt.rem   = ge ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
    data_nxt.quo   = {up_data.quo[ETA_W-2:0], ge};
    data_nxt.dbits = {up_data.dbits[ETA_W-2:0], 1'b0};
  end

  // Advance when the next cell can take the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

[rtl/rrru_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// rrru_sqrt_cell: one digit step of the integer square-root chain
// Brings down two radicand bits, trial-subtracts 4*root+1 and emits one
// root bit, then hands the beat to the next cell.
// ----------------------------------------------------------------------------
module rrru_sqrt_cell
  import rrru_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  sq_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output sq_t  dn_data
);

  logic              valid_r;
  sq_t               data_r;
  sq_t               data_nxt;
  logic [SQ_W+3:0]   cur;
  logic [SQ_W+3:0]   sub;
  logic [SQ_W+3:0]   diff;
  logic              ge;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Trial subtract and shift one root bit in
  always_comb begin
    cur      = {up_data.rem, up_data.rad[RAD_W-1 -: 2]};
    sub      = {2'b00, up_data.root, 2'b01};
    diff     = cur - sub;
    ge       = (cur >= sub);
    data_nxt = up_data;
    data_nxt.rem  = ge ? diff[SQ_W+1:0] : cur[SQ_W+1:0];
    data_nxt.root = {up_data.root[SQ_W-2:0], ge};
    data_nxt.rad  = {up_data.rad[RAD_W-3:0], 2'b00};
  end

  // Advance when the next cell can take the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

[rtl/ray_reflect_refract_unit.sv]
// ----------------------------------------------------------------------------
// ray_reflect_refract_unit: mirror reflection and Snell refraction of rays
// Fixed-point direction pipeline built from a divider cell chain, a square
// root cell chain and a few arithmetic stages.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on in_t*: incident and normal vectors (Q2.16), the two
//   refractive indices (Q4.12) in in_tdata, the mode in in_tuser
//   (0 reflect, 1 refract). Each beat yields exactly one output beat on
//   out_t*: the direction (Q5.16, saturated) in out_tdata and the total
//   internal reflection flag in out_tuser.
//   The path runs through 20 divider cells for eta, 7 arithmetic stages,
//   23 square-root cells and 2 final stages. Throughput is one beat per
//   cycle while out_tready is high; each cell and stage holds one beat.
//   Every stage keeps its own valid bit and advances when the stage after
//   it is empty or advancing, so a stalled receiver fills the pipeline
//   from the output backward while in_tready stays high until the stage
//   at the input is occupied. Beats are never dropped or repeated.
//   Reset clears all valid bits; the pipeline is empty afterward.
// ----------------------------------------------------------------------------
module ray_reflect_refract_unit
  import rrru_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata: incident_x, incident_y, incident_z, normal_x, normal_y,
  //           normal_z, index_from, index_to, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: mode
  input  logic [0:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: out_x, out_y, out_z, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: total_internal
  output logic [0:0]            out_tuser
);

  // --------------------------------------------------------------------------
  // Divider chain for eta = index_from / index_to
  // --------------------------------------------------------------------------
  logic                   dv_v   [0:ETA_W];
  logic                   dv_rdy [0:ETA_W];
  div_t                   dv_d   [0:ETA_W];
  logic [IDX_W-1:0]       in_from;
  logic                   pr_rdy;

  assign in_from = in_tdata[6*VEC_W +: IDX_W];

  // Split the input beat into the divider payload
  always_comb begin
    dv_d[0].mode = in_tuser[0];
    for (int k = 0; k < 3; k++) begin
      dv_d[0].iv[k] = in_tdata[k*VEC_W +: VEC_W];
      dv_d[0].nv[k] = in_tdata[(3+k)*VEC_W +: VEC_W];
    end
    dv_d[0].to_v  = in_tdata[6*VEC_W+IDX_W +: IDX_W];
    dv_d[0].dbits = {in_from[EXT_W-1:0], {FRAC_BITS{1'b0}}};
    dv_d[0].rem   = IDX_W'(in_from >> EXT_W);
    dv_d[0].quo   = '0;
    dv_d[0].sat   = ({{EXT_W{1'b0}}, in_from} >= {dv_d[0].to_v, {EXT_W{1'b0}}});
  end

  assign dv_v[0]       = in_tvalid;
  assign in_tready     = dv_rdy[0];
  assign dv_rdy[ETA_W] = pr_rdy;

  for (genvar g = 0; g < ETA_W; g++) begin : g_div
    rrru_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_v[g]),
      .up_ready (dv_rdy[g]),
      .up_data  (dv_d[g]),
      .dn_valid (dv_v[g+1]),
      .dn_ready (dv_rdy[g+1]),
      .dn_data  (dv_d[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage control: each stage moves when its successor can take a beat
  // --------------------------------------------------------------------------
  logic pr_v_r, dt_v_r, fl_v_r, mu_v_r, rs_v_r, eq_v_r, tt_v_r, mk_v_r, fo_v_r;
  logic dt_rdy, fl_rdy, mu_rdy, rs_rdy, eq_rdy, tt_rdy, mk_rdy, fo_rdy;
  logic sq_v   [0:SQ_W];
  logic sq_rdy [0:SQ_W];
  sq_t  sq_d   [0:SQ_W];

  assign fo_rdy = !fo_v_r || out_tready;
  assign mk_rdy = !mk_v_r || fo_rdy;
  assign tt_rdy = !tt_v_r || sq_rdy[0];
  assign eq_rdy = !eq_v_r || tt_rdy;
  assign rs_rdy = !rs_v_r || eq_rdy;
  assign mu_rdy = !mu_v_r || rs_rdy;
  assign fl_rdy = !fl_v_r || mu_rdy;
  assign dt_rdy = !dt_v_r || fl_rdy;
  assign pr_rdy = !pr_v_r || dt_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_v_r <= 1'b0;
      dt_v_r <= 1'b0;
      fl_v_r <= 1'b0;
      mu_v_r <= 1'b0;
      rs_v_r <= 1'b0;
      eq_v_r <= 1'b0;
      tt_v_r <= 1'b0;
      mk_v_r <= 1'b0;
      fo_v_r <= 1'b0;
    end else begin
      if (pr_rdy) pr_v_r <= dv_v[ETA_W];
      if (dt_rdy) dt_v_r <= pr_v_r;
      if (fl_rdy) fl_v_r <= dt_v_r;
      if (mu_rdy) mu_v_r <= fl_v_r;
      if (rs_rdy) rs_v_r <= mu_v_r;
      if (eq_rdy) eq_v_r <= rs_v_r;
      if (tt_rdy) tt_v_r <= eq_v_r;
      if (mk_rdy) mk_v_r <= sq_v[SQ_W];
      if (fo_rdy) fo_v_r <= mk_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Products stage: saturate eta, multiply components
  // --------------------------------------------------------------------------
  logic                   pr_mode_r;
  logic [2:0][VEC_W-1:0]  pr_iv_r, pr_nv_r;
  logic [ETA_W-1:0]       pr_eta_r;
  logic [2:0][PRD_W-1:0]  pr_p_r;

  always_ff @(posedge clk) begin
    if (dv_v[ETA_W] && pr_rdy) begin
      pr_mode_r <= dv_d[ETA_W].mode;
      pr_iv_r   <= dv_d[ETA_W].iv;
      pr_nv_r   <= dv_d[ETA_W].nv;
      pr_eta_r  <= dv_d[ETA_W].sat ? ETA_MAX : dv_d[ETA_W].quo;
      for (int k = 0; k < 3; k++) begin
        pr_p_r[k] <= PRD_W'($signed(dv_d[ETA_W].iv[k])) * PRD_W'($signed(dv_d[ETA_W].nv[k]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Dot stage: sum the component products
  // --------------------------------------------------------------------------
  logic                       dt_mode_r;
  logic [2:0][VEC_W-1:0]      dt_iv_r, dt_nv_r;
  logic [ETA_W-1:0]           dt_eta_r;
  logic signed [DOT_W-1:0]    dt_dot_r;

  always_ff @(posedge clk) begin
    if (pr_v_r && dt_rdy) begin
      dt_mode_r <= pr_mode_r;
      dt_iv_r   <= pr_iv_r;
      dt_nv_r   <= pr_nv_r;
      dt_eta_r  <= pr_eta_r;
      dt_dot_r  <= DOT_W'($signed(pr_p_r[0])) + DOT_W'($signed(pr_p_r[1]))
                 + DOT_W'($signed(pr_p_r[2]));
    end
  end

  // --------------------------------------------------------------------------
  // Flip stage: orient the normal for refraction, round the cosine
  // --------------------------------------------------------------------------
  logic                       fl_flip;
  logic signed [DOT_W-1:0]    fl_adot;
  logic signed [63:0]         fl_kr, fl_cr;
  logic [2:0][NVF_W-1:0]      fl_nvf;
  logic                       fl_mode_r;
  logic [2:0][VEC_W-1:0]      fl_iv_r;
  logic [2:0][NVF_W-1:0]      fl_nvf_r;
  logic [ETA_W-1:0]           fl_eta_r;
  logic signed [KF_W-1:0]     fl_kf_r;
  logic [COS_W-1:0]           fl_c_r;

  always_comb begin
    fl_flip = dt_mode_r && (dt_dot_r <= 0);
    fl_adot = fl_flip ? -dt_dot_r : dt_dot_r;
    fl_kr   = rescale(64'(dt_dot_r));
    fl_cr   = rescale(64'(fl_adot));
    for (int k = 0; k < 3; k++) begin
      fl_nvf[k] = fl_flip ? -NVF_W'($signed(dt_nv_r[k])) : NVF_W'($signed(dt_nv_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (dt_v_r && fl_rdy) begin
      fl_mode_r <= dt_mode_r;
      fl_iv_r   <= dt_iv_r;
      fl_nvf_r  <= fl_nvf;
      fl_eta_r  <= dt_eta_r;
      fl_kf_r   <= fl_kr[KF_W-1:0];
      fl_c_r    <= (fl_cr > 64'(COS_MAX)) ? COS_MAX : fl_cr[COS_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Multiply stage: eta^2, c^2, eta*c and the reflection products
  // --------------------------------------------------------------------------
  logic                         mu_mode_r;
  logic [2:0][VEC_W-1:0]        mu_iv_r;
  logic [2:0][NVF_W-1:0]        mu_nvf_r;
  logic [ETA_W-1:0]             mu_eta_r;
  logic [2*ETA_W-1:0]           mu_e2p_r;
  logic [2*COS_W-1:0]           mu_cc2_r;
  logic [ETA_W+COS_W-1:0]       mu_ecp_r;
  logic [2:0][KN_W-1:0]         mu_kn_r;

  always_ff @(posedge clk) begin
    if (fl_v_r && mu_rdy) begin
      mu_mode_r <= fl_mode_r;
      mu_iv_r   <= fl_iv_r;
      mu_nvf_r  <= fl_nvf_r;
      mu_eta_r  <= fl_eta_r;
      mu_e2p_r  <= (2*ETA_W)'(fl_eta_r) * (2*ETA_W)'(fl_eta_r);
      mu_cc2_r  <= (2*COS_W)'(fl_c_r) * (2*COS_W)'(fl_c_r);
      mu_ecp_r  <= (ETA_W+COS_W)'(fl_eta_r) * (ETA_W+COS_W)'(fl_c_r);
      for (int k = 0; k < 3; k++) begin
        mu_kn_r[k] <= KN_W'(fl_kf_r) * KN_W'($signed(fl_nvf_r[k]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Rescale stage: round products, finish the reflected direction
  // --------------------------------------------------------------------------
  logic signed [63:0]           rs_e2, rs_q, rs_ec;
  logic [2:0][OUT_W-1:0]        rs_refl;
  logic                         rs_mode_r;
  logic [2:0][VEC_W-1:0]        rs_iv_r;
  logic [2:0][NVF_W-1:0]        rs_nvf_r;
  logic [ETA_W-1:0]             rs_eta_r;
  logic [EC_W-1:0]              rs_ecr_r;
  logic [2:0][OUT_W-1:0]        rs_refl_r;
  logic [E2_W-1:0]              rs_e2_r;
  logic signed [Q_W-1:0]        rs_q_r;

  always_comb begin
    rs_e2 = rescale(64'(mu_e2p_r));
    rs_q  = rescale(64'(mu_cc2_r) - ONE_SQ);
    rs_ec = rescale(64'(mu_ecp_r));
    for (int k = 0; k < 3; k++) begin
      rs_refl[k] = sat_out(rescale((64'($signed(mu_iv_r[k])) <<< FRAC_BITS)
                                   - (64'($signed(mu_kn_r[k])) <<< 1)));
    end
  end

  always_ff @(posedge clk) begin
    if (mu_v_r && rs_rdy) begin
      rs_mode_r <= mu_mode_r;
      rs_iv_r   <= mu_iv_r;
      rs_nvf_r  <= mu_nvf_r;
      rs_eta_r  <= mu_eta_r;
      rs_ecr_r  <= rs_ec[EC_W-1:0];
      rs_refl_r <= rs_refl;
      rs_e2_r   <= rs_e2[E2_W-1:0];
      rs_q_r    <= rs_q[Q_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Product stage: eta^2 * (c^2 - 1)
  // --------------------------------------------------------------------------
  logic                         eq_mode_r;
  logic [2:0][VEC_W-1:0]        eq_iv_r;
  logic [2:0][NVF_W-1:0]        eq_nvf_r;
  logic [ETA_W-1:0]             eq_eta_r;
  logic [EC_W-1:0]              eq_ecr_r;
  logic [2:0][OUT_W-1:0]        eq_refl_r;
  logic signed [EQ_W-1:0]       eq_prod_r;

  always_ff @(posedge clk) begin
    if (rs_v_r && eq_rdy) begin
      eq_mode_r <= rs_mode_r;
      eq_iv_r   <= rs_iv_r;
      eq_nvf_r  <= rs_nvf_r;
      eq_eta_r  <= rs_eta_r;
      eq_ecr_r  <= rs_ecr_r;
      eq_refl_r <= rs_refl_r;
      eq_prod_r <= EQ_W'($signed({1'b0, rs_e2_r})) * EQ_W'(rs_q_r);
    end
  end

  // --------------------------------------------------------------------------
  // T stage: t = 1 + rounded product, detect total internal reflection
  // --------------------------------------------------------------------------
  logic signed [63:0] tt_t;
  sq_t                tt_nxt;

  always_comb begin
    tt_t          = ONE + rescale(64'(eq_prod_r));
    tt_nxt.mode   = eq_mode_r;
    tt_nxt.tir    = eq_mode_r && (tt_t < 0);
    tt_nxt.iv     = eq_iv_r;
    tt_nxt.nvf    = eq_nvf_r;
    tt_nxt.eta    = eq_eta_r;
    tt_nxt.ecr    = eq_ecr_r;
    tt_nxt.refl   = eq_refl_r;
    tt_nxt.rad    = (tt_t < 0) ? '0 : {tt_t[RAD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    tt_nxt.rem    = '0;
    tt_nxt.root   = '0;
  end

  always_ff @(posedge clk) begin
    if (eq_v_r && tt_rdy) begin
      sq_d[0] <= tt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Square-root chain for sqrt(t * 2^F)
  // --------------------------------------------------------------------------
  assign sq_v[0]      = tt_v_r;
  assign sq_rdy[SQ_W] = mk_rdy;

  for (genvar g = 0; g < SQ_W; g++) begin : g_sqrt
    rrru_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_v[g]),
      .up_ready (sq_rdy[g]),
      .up_data  (sq_d[g]),
      .dn_valid (sq_v[g+1]),
      .dn_ready (sq_rdy[g+1]),
      .dn_data  (sq_d[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Refraction products: eta*i and (eta*c - sqrt t)*n
  // --------------------------------------------------------------------------
  logic signed [M_W-1:0]        mk_m;
  logic                         mk_mode_r;
  logic                         mk_tir_r;
  logic [2:0][OUT_W-1:0]        mk_refl_r;
  logic [2:0][EI_W-1:0]         mk_ei_r;
  logic [2:0][MN_W-1:0]         mk_mn_r;

  assign mk_m = M_W'($signed({1'b0, sq_d[SQ_W].ecr}))
              - M_W'($signed({1'b0, sq_d[SQ_W].root}));

  always_ff @(posedge clk) begin
    if (sq_v[SQ_W] && mk_rdy) begin
      mk_mode_r <= sq_d[SQ_W].mode;
      mk_tir_r  <= sq_d[SQ_W].tir;
      mk_refl_r <= sq_d[SQ_W].refl;
      for (int k = 0; k < 3; k++) begin
        mk_ei_r[k] <= EI_W'($signed({1'b0, sq_d[SQ_W].eta}))
                    * EI_W'($signed(sq_d[SQ_W].iv[k]));
        mk_mn_r[k] <= MN_W'(mk_m) * MN_W'($signed(sq_d[SQ_W].nvf[k]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: finish refraction, select by mode, hold for the receiver
  // --------------------------------------------------------------------------
  logic [2:0][OUT_W-1:0]  fo_sel;
  logic [2:0][OUT_W-1:0]  fo_dir_r;
  logic                   fo_tir_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!mk_mode_r) begin
        fo_sel[k] = mk_refl_r[k];
      end else if (mk_tir_r) begin
        fo_sel[k] = '0;
      end else begin
        fo_sel[k] = sat_out(rescale(64'($signed(mk_ei_r[k])) - 64'($signed(mk_mn_r[k]))));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mk_v_r && fo_rdy) begin
      fo_dir_r <= fo_sel;
      fo_tir_r <= mk_tir_r;
    end
  end

  assign out_tvalid = fo_v_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, fo_dir_r};
  assign out_tuser  = fo_tir_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[3*OUT_W-1:0] == '0))
    else $error("total internal reflection beat carries a nonzero direction");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the output stage is empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat present right after reset");

endmodule

[test/ray_reflect_refract_unit_tb.sv]
// ----------------------------------------------------------------------------
// ray_reflect_refract_unit_tb: self-checking bench for the reflect/refract unit
// Drives directed and random rays through the stream input under several
// idle/stall patterns, predicts each direction in fixed point and compares
// every output beat in order against the predicted queue.
// ----------------------------------------------------------------------------
module ray_reflect_refract_unit_tb;
  import rrru_pkg::*;

  typedef struct {
    logic                    mode;
    logic signed [VEC_W-1:0] iv [3];
    logic signed [VEC_W-1:0] nv [3];
    logic [IDX_W-1:0]        from_idx;
    logic [IDX_W-1:0]        to_idx;
  } ray_t;

  typedef struct {
    logic [OUT_W-1:0] dir [3];
    logic             tir;
  } dir_t;

  // Round to nearest, ties toward plus infinity
  function automatic longint round_fx(longint v);
    return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    for (b = 64'sd1 <<< 31; b > 0; b = b >>> 1)
      if ((r + b) * (r + b) <= v) r = r + b;
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(longint v);
    longint c;
    c = v;
    if (c > (64'sd1 <<< (OUT_W - 1)) - 1) c = (64'sd1 <<< (OUT_W - 1)) - 1;
    if (c < -(64'sd1 <<< (OUT_W - 1))) c = -(64'sd1 <<< (OUT_W - 1));
    return c[OUT_W-1:0];
  endfunction

  // Compute the bent or mirrored direction of one ray
  function automatic dir_t bend_ray(ray_t r);
    dir_t   o;
    longint i [3], n [3], d [3];
    longint one, dt, kf, c, eta, e2, q, t, s, m;
    one = 64'sd1 <<< FRAC_BITS;
    o.tir = 1'b0;
    for (int k = 0; k < 3; k++) begin
      i[k] = longint'(r.iv[k]);
      n[k] = longint'(r.nv[k]);
    end
    dt = i[0] * n[0] + i[1] * n[1] + i[2] * n[2];
    if (!r.mode) begin
      kf = round_fx(dt);
      for (int k = 0; k < 3; k++) d[k] = i[k] * one - 2 * kf * n[k];
    end else begin
      if (dt <= 0) begin
        dt = -dt;
        for (int k = 0; k < 3; k++) n[k] = -n[k];
      end
      c = round_fx(dt);
      if (c > (64'sd1 <<< (FRAC_BITS + 2)) - 1) c = (64'sd1 <<< (FRAC_BITS + 2)) - 1;
      if (r.to_idx == 0) eta = (64'sd1 <<< (FRAC_BITS + 4)) - 1;
      else begin
        eta = (longint'(r.from_idx) <<< FRAC_BITS) / longint'(r.to_idx);
        if (eta > (64'sd1 <<< (FRAC_BITS + 4)) - 1) eta = (64'sd1 <<< (FRAC_BITS + 4)) - 1;
      end
      e2 = round_fx(eta * eta);
      q = round_fx(c * c - one * one);
      t = one + round_fx(e2 * q);
      if (t < 0) begin
        o.tir = 1'b1;
        for (int k = 0; k < 3; k++) d[k] = 0;
      end else begin
        s = root_floor(t <<< FRAC_BITS);
        m = round_fx(eta * c) - s;
        for (int k = 0; k < 3; k++) d[k] = eta * i[k] - m * n[k];
      end
    end
    for (int k = 0; k < 3; k++) o.dir[k] = clamp_out(round_fx(d[k]));
    return o;
  endfunction

  class dir_scoreboard;
    dir_t pending [$];
    int   errors = 0;

    function void note_ray(ray_t r);
      pending.push_back(bend_ray(r));
    endfunction

    function void check_dir(logic [OUT_DATA_W-1:0] data, logic tir);
      dir_t e;
      if (pending.size() == 0) begin
        $error("output beat with no ray pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int k = 0; k < 3; k++)
        if (data[k*OUT_W +: OUT_W] !== e.dir[k]) begin
          $error("out_%s expected %0h got %0h", k == 0 ? "x" : k == 1 ? "y" : "z",
                 e.dir[k], data[k*OUT_W +: OUT_W]);
          errors++;
        end
      if (data[OUT_DATA_W-1 -: OUT_PAD_W] !== '0) begin
        $error("pad expected 0 got %0h", data[OUT_DATA_W-1 -: OUT_PAD_W]);
        errors++;
      end
      if (tir !== e.tir) begin
        $error("total_internal expected %0b got %0b", e.tir, tir);
        errors++;
      end
    endfunction
  endclass

  logic                  clk, rst_n;
  logic                  in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser, out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;

  dir_scoreboard sb;
  int idle_pct, stall_pct;
  int cycles;

  ray_reflect_refract_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: stall at random, check each accepted beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_dir(out_tdata, out_tuser[0]);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [IN_DATA_W-1:0] pack_ray(ray_t r);
    logic [IN_DATA_W-1:0] v;
    v = '0;
    for (int k = 0; k < 3; k++) begin
      v[k*VEC_W +: VEC_W] = r.iv[k];
      v[(k+3)*VEC_W +: VEC_W] = r.nv[k];
    end
    v[6*VEC_W +: IDX_W] = r.from_idx;
    v[6*VEC_W+IDX_W +: IDX_W] = r.to_idx;
    return v;
  endfunction

  // Present one beat, hold until accepted, then idle at random
  task automatic send_ray(ray_t r);
    in_tvalid <= 1'b1;
    in_tdata  <= pack_ray(r);
    in_tuser  <= r.mode;
    do @(posedge clk); while (!in_tready);
    sb.note_ray(r);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VEC_W-1:0] rand_comp();
    int s;
    s = $urandom_range(9);
    if (s < 6) return VEC_W'($signed($urandom_range(131072)) - 65536);
    if (s < 9) return VEC_W'($urandom());
    return ($urandom_range(1)) ? 18'sh1ffff : 18'sh20000;
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    r.mode = 1'($urandom_range(1));
    for (int k = 0; k < 3; k++) begin
      r.iv[k] = rand_comp();
      r.nv[k] = rand_comp();
    end
    if ($urandom_range(3) != 0) begin
      // Typical glass/water/air indices between 1.0 and 2.5
      r.from_idx = IDX_W'($urandom_range(10240, 4096));
      r.to_idx   = IDX_W'($urandom_range(10240, 4096));
    end else begin
      r.from_idx = IDX_W'($urandom());
      r.to_idx   = IDX_W'($urandom());
    end
    return r;
  endfunction

  function automatic ray_t make_ray(int md, int ix, int iy, int iz, int nx, int ny,
                                    int nz, int fi, int ti);
    ray_t r;
    r.mode = md[0];
    r.iv[0] = VEC_W'(ix); r.iv[1] = VEC_W'(iy); r.iv[2] = VEC_W'(iz);
    r.nv[0] = VEC_W'(nx); r.nv[1] = VEC_W'(ny); r.nv[2] = VEC_W'(nz);
    r.from_idx = IDX_W'(fi);
    r.to_idx = IDX_W'(ti);
    return r;
  endfunction

  initial begin
    ray_t r;
    sb = new();
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, both modes, flipped normal, grazing rays,
    // total internal reflection, zero index, saturation
    send_ray(make_ray(0, 0, 0, -65536, 0, 0, 65536, 4096, 4096));
    send_ray(make_ray(1, 0, 0, -65536, 0, 0, 65536, 4096, 6144));
    send_ray(make_ray(1, 0, 0, -65536, 0, 0, -65536, 4096, 6144));
    send_ray(make_ray(1, 46341, 0, -46341, 0, 0, 65536, 6144, 4096));
    send_ray(make_ray(1, 65536, 0, 0, 0, 0, 65536, 6144, 4096));
    send_ray(make_ray(1, 65536, 0, 0, 0, 0, 65536, 4096, 6144));
    send_ray(make_ray(1, 46341, 0, -46341, 0, 0, 65536, 4096, 0));
    send_ray(make_ray(1, 0, 0, -65536, 0, 0, 65536, 65535, 1));
    send_ray(make_ray(1, 0, 0, -65536, 0, 0, 65536, 1, 65535));
    send_ray(make_ray(1, 0, 0, 0, 0, 0, 0, 4096, 4096));
    send_ray(make_ray(0, 131071, 131071, 131071, 131071, 131071, 131071, 0, 0));
    send_ray(make_ray(0, -131072, -131072, -131072, -131072, -131072, -131072,
                      65535, 65535));
    send_ray(make_ray(1, 131071, 131071, 131071, 131071, 131071, 131071, 65535, 1));
    send_ray(make_ray(1, -131072, -131072, -131072, -131072, -131072, -131072,
                      65535, 65535));
    send_ray(make_ray(1, -131072, 131071, -131072, 131071, -131072, 131071, 0, 65535));
    send_ray(make_ray(0, 1, 1, 1, 1, 1, 1, 1, 1));
    send_ray(make_ray(1, 1, 1, 1, -1, -1, -1, 1, 1));
    // Hold off until everything is back
    drain();

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 55 : (ph == 3) ? 38 : 0;
      stall_pct = (ph == 2) ? 55 : (ph == 3) ? 38 : 0;
      for (int n = 0; n < 425; n++) begin
        r = rand_ray();
        send_ray(r);
      end
      drain();
    end
    stall_pct = 0;
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
